// File: rtl/xtkbd_pkg.sv
// shared types and constants for the xt keyboard and system-control port
package xtkbd_pkg;

  // event codes carried in the opcode field
  localparam logic [2:0] OP_PORTB_WR = 3'd0;
  localparam logic [2:0] OP_PORTA_RD = 3'd1;
  localparam logic [2:0] OP_PORTC_RD = 3'd2;
  localparam logic [2:0] OP_KBD_CLK  = 3'd3;
  localparam logic [2:0] OP_KBD_DATA = 3'd4;
  localparam logic [2:0] OP_TIMER2   = 3'd5;

  // port b bit positions
  localparam int unsigned PB_GATE2   = 0;
  localparam int unsigned PB_SPKDATA = 1;
  localparam int unsigned PB_SWHIGH  = 3;
  localparam int unsigned PB_KBCLK   = 6;
  localparam int unsigned PB_CLEAR   = 7;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic       line_level;
    logic [7:0] write_data;
    logic [2:0] opcode;
  } item_t;

  typedef struct packed {
    logic       speaker_level;
    logic       timer2_gate;
    logic       keyboard_clock_drive;
    logic       irq1_level;
    logic [7:0] read_data;
  } result_t;

endpackage

// File: rtl/xtkbd_core.sv
// port latches, keyboard shift register and per-event update logic
module xtkbd_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [7:0]             cfg_wdata,
  input  logic                   item_fire,
  input  xtkbd_pkg::item_t       item,
  output xtkbd_pkg::result_t     result
);

  logic [7:0] dip_r;
  logic [7:0] port_b_r, port_b_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       shift_en_r, shift_en_nxt;
  logic       clk_line_r, clk_line_nxt;
  logic       data_line_r, data_line_nxt;
  logic       irq1_r, irq1_nxt;
  logic       clk_drive_r, clk_drive_nxt;
  logic       t2_out_r, t2_out_nxt;
  logic [7:0] rd;
  logic [3:0] sw_nib;

  always_comb begin
    port_b_nxt    = port_b_r;
    shift_nxt     = shift_r;
    shift_en_nxt  = shift_en_r;
    clk_line_nxt  = clk_line_r;
    data_line_nxt = data_line_r;
    irq1_nxt      = irq1_r;
    clk_drive_nxt = clk_drive_r;
    t2_out_nxt    = t2_out_r;
    rd            = 8'h00;
    sw_nib        = port_b_r[xtkbd_pkg::PB_SWHIGH] ? dip_r[7:4] : dip_r[3:0];
    case (item.opcode)
      xtkbd_pkg::OP_PORTB_WR: begin
        port_b_nxt    = item.write_data;
        clk_line_nxt  = item.write_data[xtkbd_pkg::PB_KBCLK];
        clk_drive_nxt = item.write_data[xtkbd_pkg::PB_KBCLK];
        if (item.write_data[xtkbd_pkg::PB_CLEAR]) begin
          irq1_nxt     = 1'b0;
          shift_nxt    = 8'h00;
          shift_en_nxt = 1'b1;
        end
      end
      xtkbd_pkg::OP_PORTA_RD: begin
        rd = port_b_r[xtkbd_pkg::PB_CLEAR] ? dip_r : shift_r;
      end
      xtkbd_pkg::OP_PORTC_RD: begin
        rd = {2'b00, t2_out_r,
              (port_b_r[xtkbd_pkg::PB_GATE2] ? t2_out_r : 1'b1), sw_nib};
      end
      xtkbd_pkg::OP_KBD_CLK: begin
        // only a real level change with clock enabled and shifting on counts
        if (item.line_level != clk_line_r && port_b_r[xtkbd_pkg::PB_KBCLK]
            && shift_en_r) begin
          clk_line_nxt = item.line_level;
          if (!port_b_r[xtkbd_pkg::PB_CLEAR] && !item.line_level) begin
            shift_nxt = {data_line_r, shift_r[7:1]};
            if (shift_r[0]) begin
              irq1_nxt      = 1'b1;
              shift_en_nxt  = 1'b0;
              clk_line_nxt  = 1'b0;
              clk_drive_nxt = 1'b0;
            end
          end
        end
      end
      xtkbd_pkg::OP_KBD_DATA: data_line_nxt = item.line_level;
      xtkbd_pkg::OP_TIMER2:   t2_out_nxt    = item.line_level;
      default: ;
    endcase
  end

  assign result.read_data            = rd;
  assign result.irq1_level           = irq1_nxt;
  assign result.keyboard_clock_drive = clk_drive_nxt;
  assign result.timer2_gate          = port_b_nxt[xtkbd_pkg::PB_GATE2];
  assign result.speaker_level        = port_b_nxt[xtkbd_pkg::PB_SPKDATA] & t2_out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dip_r       <= 8'h00;
      port_b_r    <= 8'h00;
      shift_r     <= 8'h00;
      shift_en_r  <= 1'b0;
      clk_line_r  <= 1'b0;
      data_line_r <= 1'b0;
      irq1_r      <= 1'b0;
      clk_drive_r <= 1'b0;
      t2_out_r    <= 1'b1;
    end else begin
      if (cfg_wen) begin
        dip_r <= cfg_wdata;
      end
      if (item_fire) begin
        port_b_r    <= port_b_nxt;
        shift_r     <= shift_nxt;
        shift_en_r  <= shift_en_nxt;
        clk_line_r  <= clk_line_nxt;
        data_line_r <= data_line_nxt;
        irq1_r      <= irq1_nxt;
        clk_drive_r <= clk_drive_nxt;
        t2_out_r    <= t2_out_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  // a pending interrupt always has shifting stopped
  a_irq_stops_shift: assert property (@(posedge clk) disable iff (!rst_n)
    irq1_r |-> !shift_en_r)
    else $error("irq1 pending while shifting is enabled");

  // the board never drives the clock high unless port b enables it
  a_drive_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    clk_drive_r |-> port_b_r[xtkbd_pkg::PB_KBCLK])
    else $error("clock drive high with port b clock enable low");

  // a completed shift-out clears the shift enable on the next cycle
  a_shift_out_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item.opcode == xtkbd_pkg::OP_KBD_CLK && irq1_nxt && !irq1_r)
      |=> (!shift_en_r && !clk_drive_r))
    else $error("shift-out did not stop shifting and drop clock drive");
`endif

endmodule

// File: rtl/xt_keyboard_port_interface.sv
// top level of the xt keyboard and system-control port with stream channels
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   in_tdata: opcode, write_data, line_level
//  out_     out  out_tvalid/out_tready out_tdata: read_data, irq1, clk drive,
//                                      timer2 gate, speaker
//  cfg_     in   cfg_wen               cfg_wdata: dip_switches
//
// one transfer per cycle sustained while out_tready stays high; an item goes
// through the input register, then the event logic into the result register
// the latch state is updated as an item leaves the input register, so events
// apply strictly in arrival order
// rst_n is synchronous, active low; it empties both stages and resets latches
// a stalled output holds both stages; in_tready drops only when the input
// register is full and cannot move on
module xt_keyboard_port_interface (
  input  logic                                clk,
  input  logic                                rst_n,
  // opcode [2:0], write_data [10:3], line_level [11], zero [15:12]
  input  logic [xtkbd_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // read_data [7:0], irq1_level [8], keyboard_clock_drive [9],
  // timer2_gate [10], speaker_level [11], zero [15:12]
  output logic [xtkbd_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wen,
  input  logic [7:0]                          cfg_wdata
);

  // input register stage
  logic               in_valid_r;
  xtkbd_pkg::item_t   in_item_r;
  // result register stage
  logic               out_valid_r;
  xtkbd_pkg::result_t out_res_r;

  xtkbd_pkg::result_t res;
  logic               res_fire;   // item leaves input register, latches update
  logic               in_fire;

  // result register can take a new value when empty or being drained
  assign res_fire  = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || res_fire;
  assign in_fire   = in_tvalid && in_tready;

  xtkbd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .item_fire (res_fire),
    .item      (in_item_r),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r <= in_tdata[$bits(xtkbd_pkg::item_t)-1:0];
    end
    if (res_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(xtkbd_pkg::OUT_TDATA_W - $bits(xtkbd_pkg::result_t)){1'b0}},
                       out_res_r};

`ifndef SYNTHESIS
  // an item moving on always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> out_valid_r)
    else $error("result register empty after item moved on");

  // a full input register that could not move on must block new transfers
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input register overwritten while stalled");

  // a result still waiting keeps its value
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_res_r)))
    else $error("waiting result changed or vanished");
`endif

endmodule
